// ===== sv/scale_note_frequency_map_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scale note frequency map
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCALE_NOTE_FREQUENCY_MAP_ASSERT_SVH
`define SCALE_NOTE_FREQUENCY_MAP_ASSERT_SVH

`ifndef SYNTH

// Property that must hold on every clock edge outside reset.
`define SNFM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("snfm assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define SNFM_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("snfm assertion failed");

`else

`define SNFM_ASSERT(lbl, prop)
`define SNFM_ASSERT_NEXT(lbl, cond, cons)

`endif

`endif

// ===== sv/snfm_pkg.sv =====
// ----------------------------------------------------------------------------
// snfm_pkg
// Types, codes and constants shared by the note frequency map modules.
// ----------------------------------------------------------------------------
package snfm_pkg;

    // Operation codes carried in the input tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_RATIO = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_FREQ     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_NOTE  = 8'd3;

    // Number formats.
    localparam logic [31:0] RATIO_ONE   = 32'h1000_0000;
    localparam logic [31:0] RATIO_TWO   = 32'h2000_0000;
    localparam logic [31:0] OCT_FLOOR   = 32'd2;
    localparam logic [39:0] FREQ_MAX    = 40'hFF_FFFF_FFFF;
    localparam logic [63:0] ROUND_HALF  = 64'h0000_0000_0800_0000;
    localparam logic [6:0]  TET_STEPS   = 7'd12;
    localparam logic [6:0]  CENTER_RST  = 7'd69;
    localparam logic [39:0] REF_HZ      = 40'd440;
    localparam logic [5:0]  DIV_LAST    = 6'd39;

    // Equal-tempered ratios 2^(k/12) in Q4.28.
    function automatic logic [31:0] tet_ratio(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd0:    r = 32'd268435456;
            4'd1:    r = 32'd284397459;
            4'd2:    r = 32'd301308612;
            4'd3:    r = 32'd319225354;
            4'd4:    r = 32'd338207482;
            4'd5:    r = 32'd358318345;
            4'd6:    r = 32'd379625062;
            4'd7:    r = 32'd402198743;
            4'd8:    r = 32'd426114725;
            4'd9:    r = 32'd451452825;
            4'd10:   r = 32'd478297607;
            4'd11:   r = 32'd506738663;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_OCT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_FIX,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_DONE,
        ST_DEG_SEL,
        ST_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic write;
        logic split;
        logic mul_lo;
        logic mul_hi;
        logic mul_fix;
        logic use_deg;
        logic div_init;
        logic div_step;
        logic div_done;
        logic deg_sel;
        logic emit;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic in_query;
        logic in_note_ok;
        logic split_done;
        logic cnt_zero;
        logic q_neg;
        logic sat;
        logic div_ovf;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ===== sv/scale_note_frequency_map.sv =====
// ----------------------------------------------------------------------------
// scale_note_frequency_map
// Note number to frequency conversion under a loadable microtonal scale.
// ----------------------------------------------------------------------------
// A write word (tuser 0) loads one degree ratio. A query word (tuser 1) is
// set up, then splits the note offset into octaves and a degree by repeated
// addition or subtraction of the scale length, then per octave multiplies
// upward (low, high and fix-up steps through one shared 32x32 multiplier) or
// divides downward (bit-serial divider, one quotient bit a cycle for 40 bits),
// then does the degree multiply and loads the output register once it is free.
// Input is taken only between queries; a finished result waits in the output
// register while the next word is accepted.
// Configuration writes are always ready. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module scale_note_frequency_map
    import snfm_pkg::*;
#(
    parameter int MAX_DEGREES    = 128,
    parameter int NOTE_COUNT     = 128,
    parameter int FREQ_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [39:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // degree_index[6:0], degree_ratio[38:7], note_number[45:39], zero fill
    input  logic [47:0]          s_tdata,
    // operation[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_note[6:0], frequency[46:7], zero fill
    output logic [47:0]          m_tdata,
    // saturated[0]
    output logic                 m_tuser
);

    cmd_t    cmd;
    status_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer.
    snfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath.
    snfm_dp #(
        .MAX_DEGREES    (MAX_DEGREES),
        .NOTE_COUNT     (NOTE_COUNT),
        .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== sv/snfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// snfm_ctrl
// Sequencer for one item: octave split, octave multiplies or divides,
// degree multiply and result hand-off.
// ----------------------------------------------------------------------------
module snfm_ctrl
    import snfm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output cmd_t    cmd,
    input  status_t sts
);

    state_t state_reg, state_next;
    logic   deg_phase_reg, deg_phase_next;

    // State and phase registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            deg_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deg_phase_reg <= deg_phase_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        deg_phase_next = deg_phase_reg;
        cmd            = '0;
        cmd.use_deg    = deg_phase_reg;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!sts.in_query)
                    begin
                        cmd.write = 1'b1;
                    end
                    else if (sts.in_note_ok)
                    begin
                        cmd.load       = 1'b1;
                        deg_phase_next = 1'b0;
                        state_next     = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT:
            begin
                cmd.split = 1'b1;
                if (sts.split_done)
                begin
                    state_next = ST_OCT;
                end
            end
            ST_OCT:
            begin
                if (sts.sat)
                begin
                    state_next = ST_OUT;
                end
                else if (sts.cnt_zero)
                begin
                    state_next = ST_DEG_SEL;
                end
                else if (sts.q_neg)
                begin
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_FIX;
            end
            ST_MUL_FIX:
            begin
                cmd.mul_fix = 1'b1;
                state_next  = deg_phase_reg ? ST_OUT : ST_OCT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = sts.div_ovf ? ST_OCT : ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE:
            begin
                cmd.div_done = 1'b1;
                state_next   = ST_OCT;
            end
            ST_DEG_SEL:
            begin
                cmd.deg_sel    = 1'b1;
                deg_phase_next = 1'b1;
                state_next     = ST_MUL_LO;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/snfm_dp.sv =====
// ----------------------------------------------------------------------------
// snfm_dp
// Datapath: configuration registers, degree table, octave split, shared
// 32x32 multiplier, bit-serial divider and output register.
// ----------------------------------------------------------------------------
`include "scale_note_frequency_map_assert.svh"

module snfm_dp
    import snfm_pkg::*;
#(
    parameter int MAX_DEGREES    = 128,
    parameter int NOTE_COUNT     = 128,
    parameter int FREQ_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [39:0]          cfg_data,
    input  logic [47:0]          s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,
    output logic                 m_tuser,
    input  cmd_t                 cmd,
    output status_t              sts
);

    localparam int AW = $clog2(MAX_DEGREES);

    // Input fields.
    logic [6:0]  in_degree_index;
    logic [31:0] in_degree_ratio;
    logic [6:0]  in_note_number;
    assign in_degree_index = s_tdata[6:0];
    assign in_degree_ratio = s_tdata[38:7];
    assign in_note_number  = s_tdata[45:39];

    // Configuration registers.
    logic [6:0]  scale_length_reg;
    logic [31:0] octave_ratio_reg;
    logic [39:0] ref_freq_reg;
    logic [6:0]  center_note_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_length_reg <= 7'd0;
            octave_ratio_reg <= RATIO_TWO;
            ref_freq_reg     <= REF_HZ << FREQ_FRAC_BITS;
            center_note_reg  <= CENTER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCALE_LENGTH: scale_length_reg <= cfg_data[6:0];
                REG_OCTAVE_RATIO: octave_ratio_reg <= cfg_data[31:0];
                REG_REF_FREQ:     ref_freq_reg     <= cfg_data;
                REG_CENTER_NOTE:  center_note_reg  <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    // Working registers of one query.
    logic              [6:0]  note_reg;
    logic              [6:0]  len_reg;
    logic              [31:0] oct_reg;
    logic                     tet_reg;
    logic                     neg_reg;
    logic signed       [7:0]  rem_reg;
    logic              [5:0]  cnt_reg;
    logic              [39:0] f_reg;
    logic                     sat_reg;
    logic              [31:0] deg_reg;
    logic              [63:0] prod_reg;
    logic              [63:0] lo_reg;
    logic              [31:0] drem_reg;
    logic              [39:0] nsh_reg;
    logic              [5:0]  bit_cnt_reg;
    logic              [31:0] rd_reg;

    // Degree table: written by write items, read at the folded degree.
    logic [31:0] mem [MAX_DEGREES];
    logic [8:0]  wr_ext;
    logic [8:0]  d_ext;
    logic        wr_ok;
    assign wr_ext = {2'b00, in_degree_index};
    assign d_ext  = {2'b00, rem_reg[6:0]};
    assign wr_ok  = (in_degree_index != 7'd0) && (wr_ext < 9'(MAX_DEGREES));

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
        begin
            mem[wr_ext[AW-1:0]] <= in_degree_ratio;
        end
        rd_reg <= mem[d_ext[AW-1:0]];
    end

    // Setup decode for a new query.
    logic        cfg_tet;
    logic [31:0] cfg_oct;
    logic [7:0]  rel;
    assign cfg_tet = scale_length_reg <= 7'd2;
    assign cfg_oct = cfg_tet ? RATIO_TWO :
                     (octave_ratio_reg <= OCT_FLOOR) ? RATIO_ONE : octave_ratio_reg;
    assign rel     = {1'b0, in_note_number} - {1'b0, center_note_reg};

    // Octave split: remainder is in range once it lies in [0, len).
    logic split_done;
    assign split_done = !rem_reg[7] && (rem_reg[6:0] < len_reg);

    // Shared multiplier operands.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] lo_sum;
    logic [44:0] mul_res;
    assign mul_a   = cmd.mul_hi ? {24'd0, f_reg[39:32]} : f_reg[31:0];
    assign mul_b   = cmd.use_deg ? deg_reg : oct_reg;
    assign lo_sum  = lo_reg + ROUND_HALF;
    assign mul_res = {1'b0, prod_reg[39:0], 4'b0000} + {9'd0, lo_sum[63:28]};

    // Divider setup: numerator f * 2^28 + floor(r / 2), one bit of headroom.
    logic [68:0] num;
    logic        div_ovf;
    logic [32:0] trial;
    logic        ge;
    assign num     = {1'b0, f_reg, 28'd0} + {38'd0, oct_reg[31:1]};
    assign div_ovf = {3'd0, num[68:40]} >= oct_reg;
    assign trial   = {drem_reg, nsh_reg[39]};
    assign ge      = trial >= {1'b0, oct_reg};

    // Degree ratio selection.
    logic [31:0] deg_sel;
    always_comb
    begin
        if (rem_reg[6:0] == 7'd0)
        begin
            deg_sel = RATIO_ONE;
        end
        else if (tet_reg)
        begin
            deg_sel = tet_ratio(rem_reg[3:0]);
        end
        else if (d_ext < 9'(MAX_DEGREES))
        begin
            deg_sel = rd_reg;
        end
        else
        begin
            deg_sel = 32'd0;
        end
    end

    // Control-like registers of the query.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg     <= 1'b0;
            cnt_reg     <= 6'd0;
            bit_cnt_reg <= 6'd0;
        end
        else
        begin
            if (cmd.load)
            begin
                sat_reg <= 1'b0;
                cnt_reg <= 6'd0;
            end
            if (cmd.split && !split_done)
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            if (cmd.mul_fix)
            begin
                if (mul_res > {5'd0, FREQ_MAX})
                begin
                    sat_reg <= 1'b1;
                end
                if (!cmd.use_deg)
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
            if (cmd.div_init)
            begin
                bit_cnt_reg <= 6'd0;
                if (div_ovf)
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (cmd.div_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + 6'd1;
            end
            if (cmd.div_done)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    // Payload registers of the query.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            note_reg <= in_note_number;
            len_reg  <= cfg_tet ? TET_STEPS : scale_length_reg;
            oct_reg  <= cfg_oct;
            tet_reg  <= cfg_tet;
            neg_reg  <= rel[7];
            rem_reg  <= rel;
            f_reg    <= ref_freq_reg;
        end
        if (cmd.split && !split_done)
        begin
            rem_reg <= rem_reg[7] ? rem_reg + {1'b0, len_reg} : rem_reg - {1'b0, len_reg};
        end
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        end
        if (cmd.mul_hi)
        begin
            lo_reg <= prod_reg;
        end
        if (cmd.mul_fix)
        begin
            f_reg <= (mul_res > {5'd0, FREQ_MAX}) ? FREQ_MAX : mul_res[39:0];
        end
        if (cmd.div_init)
        begin
            if (div_ovf)
            begin
                f_reg <= FREQ_MAX;
            end
            drem_reg <= {3'd0, num[68:40]};
            nsh_reg  <= num[39:0];
        end
        if (cmd.div_step)
        begin
            drem_reg <= ge ? 32'(trial - {1'b0, oct_reg}) : trial[31:0];
            nsh_reg  <= {nsh_reg[38:0], ge};
        end
        if (cmd.div_done)
        begin
            f_reg <= nsh_reg;
        end
        if (cmd.deg_sel)
        begin
            deg_reg <= deg_sel;
        end
    end

    // Output register: holds one finished word until taken.
    logic        m_tvalid_reg;
    logic [6:0]  out_note_reg;
    logic [39:0] out_freq_reg;
    logic        out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_note_reg <= note_reg;
            out_freq_reg <= f_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_freq_reg, out_note_reg};
    assign m_tuser  = out_sat_reg;

    // Status to the controller.
    always_comb
    begin
        sts            = '0;
        sts.in_query   = s_tuser == OP_QUERY;
        sts.in_note_ok = {2'b00, in_note_number} < 9'(NOTE_COUNT);
        sts.split_done = split_done;
        sts.cnt_zero   = cnt_reg == 6'd0;
        sts.q_neg      = neg_reg;
        sts.sat        = sat_reg;
        sts.div_ovf    = div_ovf;
        sts.div_last   = bit_cnt_reg == DIV_LAST;
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // A clamped frequency always reads as the maximum.
    `SNFM_ASSERT(a_sat_is_max, !sat_reg || (f_reg == FREQ_MAX))
    // The folded degree is inside the scale when the degree ratio is chosen.
    `SNFM_ASSERT(a_deg_in_range, !cmd.deg_sel || (!rem_reg[7] && (rem_reg[6:0] < len_reg)))
    // An octave multiply only runs while octaves remain.
    `SNFM_ASSERT(a_oct_cnt, !(cmd.mul_fix && !cmd.use_deg) || (cnt_reg != 6'd0))
    // Each division step leaves the saturated flag clear.
    `SNFM_ASSERT_NEXT(a_div_nosat, cmd.div_step, !sat_reg)

endmodule
